// File: src/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// shared types and constants for the even-window median filter
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = SAMPLE_W + 1;
    localparam int HALF_W     = 16;
    localparam int OUT_DATA_W = SAMPLE_W + 2 * HALF_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int MODE_W      = 3;
    localparam int CAL_W       = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODEL_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_START    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CALIBRATE_START = 2'd2;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_NORMAL_A = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NORMAL_B = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CALIB    = 3'd3;
    localparam logic [CAL_W-1:0]  CAL_GO        = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CAND,
        ST_CAPT,
        ST_SCAN,
        ST_RANK,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic capt;
        logic scan;
        logic rank;
        logic sum;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic load_last;
        logic scan_last;
        logic cand_last;
    } dp_status_t;

endpackage

// File: src/wmf_ram.sv
// ----------------------------------------------------------------------------
// wmf_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module wmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/wmf_ctrl.sv
// ----------------------------------------------------------------------------
// wmf_ctrl
// sequencer: window load, rank-count selection sweep, result hand-off
// ----------------------------------------------------------------------------
module wmf_ctrl
    import wmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && status.load_last)
                begin
                    state_next = ST_CAND;
                end
            end
            ST_CAND:
            begin
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                state_next = status.cand_last ? ST_SUM : ST_CAND;
            end
            ST_SUM:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CAPT:
            begin
                cmd.capt = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_RANK:
            begin
                cmd.rank = 1'b1;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/wmf_datapath.sv
// ----------------------------------------------------------------------------
// wmf_datapath
// window store, rank counter, middle-pair capture, mean and output register
// ----------------------------------------------------------------------------
module wmf_datapath
    import wmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [SAMPLE_W-1:0]    sample_milli,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   updated,
    output logic [OUT_DATA_W-1:0]  out_data
);

    localparam int                IW     = $clog2(WINDOW);
    localparam logic [IW-1:0]     LAST   = IW'(WINDOW - 1);
    localparam logic [IW-1:0]     MID_LO = IW'(WINDOW / 2 - 1);
    localparam logic [IW-1:0]     MID_HI = IW'(WINDOW / 2);

    logic [MODE_W-1:0]          mode_reg;
    logic                       normal_start_reg;
    logic [CAL_W-1:0]           cal_start_reg;

    logic [IW-1:0]              wr_idx_reg;
    logic [IW-1:0]              cand_idx_reg;
    logic [IW-1:0]              scan_idx_reg;
    logic [IW-1:0]              rank_reg;
    logic signed [SAMPLE_W-1:0] cand_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic                       updated_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;

    logic [IW-1:0]              raddr;
    logic [SAMPLE_W-1:0]        rdata;
    logic signed [SAMPLE_W-1:0] elem;
    logic                       less;
    logic                       gate;
    logic [SAMPLE_W-1:0]        med;
    logic [HALF_W-1:0]          med_high;
    logic [HALF_W-1:0]          med_low;

    wmf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (wr_idx_reg),
        .wdata (sample_milli),
        .raddr (raddr),
        .rdata (rdata)
    );

    // read address: candidate fetch, sweep start, sweep step
    always_comb
    begin
        if (cmd.capt)
        begin
            raddr = '0;
        end
        else if (cmd.scan)
        begin
            raddr = scan_idx_reg + 1'b1;
        end
        else
        begin
            raddr = cand_idx_reg;
        end
    end

    assign elem = signed'(rdata);
    // ties broken by position so every element gets a distinct rank
    assign less = (elem < cand_reg) || ((elem == cand_reg) && (scan_idx_reg < cand_idx_reg));

    assign status.load_last = (wr_idx_reg == LAST);
    assign status.scan_last = (scan_idx_reg == LAST);
    assign status.cand_last = (cand_idx_reg == LAST);

    assign gate = (((mode_reg == MODE_NORMAL_A) || (mode_reg == MODE_NORMAL_B))
                   && normal_start_reg)
               || ((mode_reg == MODE_CALIB) && (cal_start_reg == CAL_GO));

    // halve with truncation toward zero
    assign med      = sum_reg[SUM_W-1:1] + {{(SAMPLE_W-1){1'b0}},
                                            sum_reg[SUM_W-1] & sum_reg[0]};
    assign med_high = med[SAMPLE_W-1] ? '0 : med[SAMPLE_W-1:HALF_W];
    assign med_low  = med[SAMPLE_W-1] ? '0 : med[HALF_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= '0;
            normal_start_reg <= 1'b0;
            cal_start_reg    <= '0;
            wr_idx_reg       <= '0;
            cand_idx_reg     <= '0;
            scan_idx_reg     <= '0;
            rank_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODEL_MODE:      mode_reg         <= cfg_data[MODE_W-1:0];
                    CFG_NORMAL_START:    normal_start_reg <= cfg_data[0];
                    CFG_CALIBRATE_START: cal_start_reg    <= cfg_data[CAL_W-1:0];
                    default:             mode_reg         <= mode_reg;
                endcase
            end
            if (cmd.load)
            begin
                wr_idx_reg <= status.load_last ? '0 : wr_idx_reg + 1'b1;
            end
            if (cmd.capt)
            begin
                scan_idx_reg <= '0;
                rank_reg     <= '0;
            end
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                rank_reg     <= rank_reg + IW'(less);
            end
            if (cmd.rank)
            begin
                cand_idx_reg <= status.cand_last ? '0 : cand_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capt)
        begin
            cand_reg <= elem;
        end
        if (cmd.rank && (rank_reg == MID_LO))
        begin
            lo_reg <= cand_reg;
        end
        if (cmd.rank && (rank_reg == MID_HI))
        begin
            hi_reg <= cand_reg;
        end
        if (cmd.sum)
        begin
            sum_reg <= SUM_W'(lo_reg) + SUM_W'(hi_reg);
        end
        if (cmd.out_load)
        begin
            updated_reg  <= gate;
            out_data_reg <= {med_low, med_high, med};
        end
    end

    assign updated  = updated_reg;
    assign out_data = out_data_reg;

endmodule

// File: src/window_median_filter.sv
// ----------------------------------------------------------------------------
// window_median_filter
// even-window median filter for signed resistance samples
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  s_axis  | in  | s_axis_tvalid/tready    | tdata[31:0] sample_milli
//  m_axis  | out | m_axis_tvalid/tready    | tdata median/high/low, tuser updated
//  cfg     | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
//  one sample per cycle while a window loads; after the last sample the
//  rank sweep reads the window store once per cycle, one candidate at a time
//  through CAND, CAPT, SCAN and RANK, then SUM and EMIT, the length of the
//  sweep set by the single read port
//  samples are refused during the sweep; a result waiting at m_axis does not
//  block loading of the next window, only the hand-off of the next result
//  reset clears the fill count, config and index registers and the output valid
// ----------------------------------------------------------------------------
module window_median_filter
    import wmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample_milli
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [31:0] median_milli, [47:32] scaled_high, [63:48] scaled_low
    output logic [0:0]             m_axis_tuser,   // [0] updated
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    wmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    wmf_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_milli (s_axis_tdata),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .updated      (m_axis_tuser[0]),
        .out_data     (m_axis_tdata)
    );

endmodule

// File: src/wmf_checker.sv
// ----------------------------------------------------------------------------
// wmf_checker
// port-level checks on the median filter result stream
// ----------------------------------------------------------------------------
module wmf_checker
    import wmf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // negative median gives zero halves
    a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[63:32] == 32'd0)
        else $error("halves not cleared for negative median");

    // non-negative median halves match its bits
    a_pos_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[31] |->
            (m_axis_tdata[47:32] == m_axis_tdata[31:16])
            && (m_axis_tdata[63:48] == m_axis_tdata[15:0]))
        else $error("halves do not match median");

    // a result is never first presented right after a sample is taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!(s_axis_tvalid && s_axis_tready)))
        else $error("result appeared right after a sample transaction");

endmodule

bind window_median_filter wmf_checker u_wmf_checker (.*);

// File: tb/sv/window_median_filter_tb.sv
// ----------------------------------------------------------------------------
// window_median_filter_tb
// self-checking bench for the even-window median filter: a short directed
// table, then phases of tabled then random register settings and random sample windows,
// with every result checked against a typed expectation or a median predictor in the bench
// ----------------------------------------------------------------------------
module window_median_filter_tb;
    import wmf_pkg::*;

    localparam int WINDOW        = WINDOW_DEF;
    localparam int ITEM_TARGET   = 1500;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 8;
    localparam int SWEEP_CYCLES  = WINDOW * (WINDOW + 3) + 16;
    localparam longint TIMEOUT_UNITS = 64'd12 * 64'd400_000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic                   NS_GO      = 1'b1;
    localparam logic [SAMPLE_W-1:0]    SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0]    SAMPLE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                  updated;
        logic [SAMPLE_W-1:0]   median_milli;
        logic [HALF_W-1:0]     scaled_high;
        logic [HALF_W-1:0]     scaled_low;
    } filter_result_t;

    typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [SAMPLE_W-1:0]   value;
        bit                    has_exp;
        filter_result_t        exp;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // [31:0] median_milli, [47:32] scaled_high, [63:48] scaled_low
    logic [0:0]             m_axis_tuser;   // [0] updated
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [MODE_W-1:0]      mode_q = '0;
    logic                   normal_q = 1'b0;
    logic [CAL_W-1:0]       cal_q = '0;
    logic signed [SAMPLE_W-1:0] window_q [WINDOW];
    int                     fill_q = 0;

    filter_result_t         median_queue [$];
    directed_row_t          directed_rows [$];
    int                     errors = 0;
    int                     items_sent = 0;
    bit                     tx_burst = 1'b0;
    bit                     rx_burst = 1'b0;
    int                     rx_wait = 0;

    window_median_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic bit gate_is_open();
        return ((mode_q == MODE_NORMAL_A || mode_q == MODE_NORMAL_B) && normal_q == NS_GO)
            || (mode_q == MODE_CALIB && cal_q == CAL_GO);
    endfunction

    function automatic bit predict_median(input logic [SAMPLE_W-1:0] sample,
                                          output filter_result_t res);
        logic signed [SAMPLE_W-1:0] sorted [WINDOW];
        logic signed [SAMPLE_W-1:0] key;
        longint                     pair_sum;
        longint                     med;
        int                         j;
        res = '0;
        window_q[fill_q] = sample;
        fill_q++;
        if (fill_q < WINDOW)
        begin
            return 1'b0;
        end
        fill_q = 0;
        sorted = window_q;
        for (int i = 1; i < WINDOW; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        pair_sum = longint'(sorted[WINDOW/2-1]) + longint'(sorted[WINDOW/2]);
        med = pair_sum / 2;
        res.updated = gate_is_open();
        res.median_milli = med[SAMPLE_W-1:0];
        if (med >= 0)
        begin
            res.scaled_high = med[2*HALF_W-1:HALF_W];
            res.scaled_low  = med[HALF_W-1:0];
        end
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODEL_MODE:      mode_q = data;
            CFG_NORMAL_START:    normal_q = data[0];
            CFG_CALIBRATE_START: cal_q = data[CAL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit has_exp,
                               input filter_result_t typed);
        int gap;
        filter_result_t res;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (predict_median(sample, res))
        begin
            median_queue.push_back(has_exp ? typed : res);
        end
    endtask

    // window boundary: wait for the last result, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (median_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure_phase(input int phase);
        logic [MODE_W-1:0]     modes [8]   = '{3'd1, 3'd2, 3'd3, 3'd3, 3'd0, 3'd7, 3'd2, 3'd1};
        logic [CFG_DATA_W-1:0] normals [8] = '{3'd1, 3'd1, 3'd0, 3'd7, 3'd1, 3'd1, 3'd6, 3'd1};
        logic [CFG_DATA_W-1:0] cals [8]    = '{3'd0, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd0, 3'd6};
        logic [MODE_W-1:0]     m;
        logic [CFG_DATA_W-1:0] n;
        logic [CFG_DATA_W-1:0] c;
        if (phase < 8)
        begin
            m = modes[phase];
            n = normals[phase];
            c = cals[phase];
        end
        else
        begin
            m = MODE_W'($urandom_range(0, 7));
            n = CFG_DATA_W'($urandom_range(0, 7));
            c = CFG_DATA_W'($urandom_range(0, 7));
            // lean toward an open gate, the rarer case
            if ($urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    m = $urandom_range(0, 1) ? MODE_NORMAL_A : MODE_NORMAL_B;
                    n[0] = NS_GO;
                end
                else
                begin
                    m = MODE_CALIB;
                    c[CAL_W-1:0] = CAL_GO;
                end
            end
        end
        write_reg(CFG_MODEL_MODE, m);
        write_reg(CFG_NORMAL_START, n);
        write_reg(CFG_CALIBRATE_START, c);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 7)));
        end
    endtask

    task automatic send_window();
        int style;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] v;
        style = $urandom_range(0, 5);
        base = $urandom();
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < WINDOW; i++)
        begin
            case (style)
                0: v = $urandom();
                1: v = SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
                2: v = base;
                3: v = $urandom_range(0, 1) ? SAMPLE_MAX - $urandom_range(0, 3)
                                            : SAMPLE_MIN + $urandom_range(0, 3);
                4: v = $urandom() & SAMPLE_MAX;
                default: v = $urandom() | SAMPLE_MIN;
            endcase
            send_sample(v, 1'b0, '0);
        end
    endtask

    // result side: random stalls, check each transaction against the oldest prediction
    always @(posedge clk)
    begin
        filter_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (median_queue.size() == 0)
                begin
                    $error("unexpected result transaction: median_milli %0h", m_axis_tdata[31:0]);
                    errors++;
                end
                else
                begin
                    want = median_queue.pop_front();
                    if (m_axis_tuser[0] !== want.updated)
                    begin
                        $error("updated: expected %0d, actual %0d", want.updated, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tdata[31:0] !== want.median_milli)
                    begin
                        $error("median_milli: expected %0h, actual %0h",
                               want.median_milli, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[47:32] !== want.scaled_high)
                    begin
                        $error("scaled_high: expected %0h, actual %0h",
                               want.scaled_high, m_axis_tdata[47:32]);
                        errors++;
                    end
                    if (m_axis_tdata[63:48] !== want.scaled_low)
                    begin
                        $error("scaled_low: expected %0h, actual %0h",
                               want.scaled_low, m_axis_tdata[63:48]);
                        errors++;
                    end
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    rx_burst = ~rx_burst;
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (rx_wait != 0)
                begin
                    m_axis_tready <= 1'b0;
                end
            end
            else if (!m_axis_tready)
            begin
                if (rx_wait > 0)
                begin
                    rx_wait--;
                end
                if (rx_wait == 0)
                begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        #TIMEOUT_UNITS;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        filter_result_t extremes_res;
        int phase;
        int n_win;

        // directed: registers incl. masked data and an unused index, then a window
        // of alternating extremes whose middle pair averages to zero after truncation
        extremes_res = '{updated: 1'b1, median_milli: '0, scaled_high: '0, scaled_low: '0};
        directed_rows.push_back('{ROW_CFG, CFG_MODEL_MODE, SAMPLE_W'(MODE_CALIB), 1'b0, '0});
        directed_rows.push_back('{ROW_CFG, CFG_CALIBRATE_START, SAMPLE_W'(CAL_GO), 1'b0, '0});
        directed_rows.push_back('{ROW_CFG, CFG_NORMAL_START, 32'd6, 1'b0, '0});
        directed_rows.push_back('{ROW_CFG, CFG_UNUSED, 32'd7, 1'b0, '0});
        for (int i = 0; i < WINDOW; i++)
        begin
            directed_rows.push_back('{ROW_SAMPLE, '0, (i % 2) ? SAMPLE_MIN : SAMPLE_MAX,
                                      i == WINDOW - 1, extremes_res});
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(directed_rows[r].index, directed_rows[r].value[CFG_DATA_W-1:0]);
            end
            else
            begin
                send_sample(directed_rows[r].value, directed_rows[r].has_exp,
                            directed_rows[r].exp);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            drain_results();
            configure_phase(phase);
            n_win = $urandom_range(1, 3);
            repeat (n_win) send_window();
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (median_queue.size() != 0) @(posedge clk);
        repeat (SWEEP_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/wmf_pkg.sv
src/wmf_ram.sv
src/wmf_ctrl.sv
src/wmf_datapath.sv
src/window_median_filter.sv
src/wmf_checker.sv
tb/sv/window_median_filter_tb.sv
